FILE: rtl/thp_sensor_compensation_core_macros.svh
// Assertion macros shared by the compensation core.
`ifndef THP_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define THP_SENSOR_COMPENSATION_CORE_MACROS_SVH

// Condition must never hold outside reset.
`define THP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define THP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define THP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/thp_pkg.sv
// Shared types, constants and helper functions of the compensation core.
`default_nettype none
package thp_pkg;

	localparam int unsigned DW      = 64;
	localparam int unsigned NUM_CAL = 8;
	localparam int unsigned AW      = 5;

	// Reading kinds.
	localparam logic [1:0] KIND_TEMP  = 2'd0;
	localparam logic [1:0] KIND_PRESS = 2'd1;
	localparam logic [1:0] KIND_HUM   = 2'd2;

	// Calibration register indexes.
	localparam logic [2:0] CAL_T1_T2    = 3'd0;
	localparam logic [2:0] CAL_T3_P1    = 3'd1;
	localparam logic [2:0] CAL_P2_P3    = 3'd2;
	localparam logic [2:0] CAL_P4_P5    = 3'd3;
	localparam logic [2:0] CAL_P6_P7    = 3'd4;
	localparam logic [2:0] CAL_P8_P9    = 3'd5;
	localparam logic [2:0] CAL_H1_H2_H3 = 3'd6;
	localparam logic [2:0] CAL_H4_H5_H6 = 3'd7;

	// Formula constants.
	localparam logic [63:0] P_TEMP_OFS  = 64'd128000;
	localparam logic [63:0] P_RAW_BASE  = 64'd1048576;
	localparam logic [63:0] P_SCALE     = 64'd3125;
	localparam logic [31:0] H_TEMP_OFS  = 32'd76800;
	localparam logic [31:0] H_ADD_B     = 32'd2097152;
	localparam logic [31:0] H_ROUND_A   = 32'd16384;
	localparam logic [31:0] H_ADD_Y     = 32'd32768;
	localparam logic [31:0] H_LIMIT     = 32'd419430400;
	localparam logic [31:0] H_ROUND_C   = 32'd8192;
	localparam logic [31:0] T_ROUND     = 32'd128;

	typedef enum logic [5:0] {
		ST_IDLE, ST_DISPATCH,
		ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
		ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
		ST_P9, ST_P10, ST_P11, ST_P12, ST_P13, ST_P14, ST_P15, ST_P16, ST_P17,
		ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8,
		ST_H9, ST_H10, ST_H11,
		ST_OUT
	} st_t;

	function automatic logic [31:0] sx8_32(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic logic [31:0] sx12_32(input logic [11:0] v);
		return {{20{v[11]}}, v};
	endfunction

	function automatic logic [31:0] sx16_32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx16_64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx32_64(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
		return 32'($signed(x) >>> s);
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
		return 64'($signed(x) >>> s);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/thp_mul.sv
// Bit-serial shift-and-add multiplier, product modulo two to the operand width.
`default_nettype none
module thp_mul import thp_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] a_in,
	input  wire logic [DW-1:0] b_in,
	output logic               busy,
	output logic [DW-1:0]      product
);

	logic [DW-1:0] a_q;
	logic [DW-1:0] b_q;
	logic [DW-1:0] acc_q;

	// Consume one multiplier bit per cycle until none are left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= '0;
			b_q   <= '0;
			acc_q <= '0;
		end else if (start) begin
			a_q   <= a_in;
			b_q   <= b_in;
			acc_q <= '0;
		end else if (b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy    = (b_q != '0);
	assign product = acc_q;

endmodule
`default_nettype wire

FILE: rtl/thp_div.sv
// Bit-serial restoring signed divider, quotient truncated toward zero.
`default_nettype none
module thp_div import thp_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               busy,
	output logic [DW-1:0]      quotient
);

	localparam int unsigned CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   diff;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	// Load magnitudes, then retire one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			neg_q <= 1'b0;
			quo_q <= '0;
			den_q <= '0;
			rem_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DW);
			neg_q <= dividend[DW-1] ^ divisor[DW-1];
			quo_q <= dividend[DW-1] ? (DW'(0) - dividend) : dividend;
			den_q <= divisor[DW-1] ? (DW'(0) - divisor) : divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = neg_q ? (DW'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

FILE: rtl/thp_sensor_compensation_core.sv
// Top level of the temperature, pressure and humidity compensation core.
//
//  channel  | signals                                       | role
//  ---------+-----------------------------------------------+------------------------
//  in       | in_valid, in_ready, action, byte_*            | raw reading request
//  out      | out_valid, out_ready, reading_*, zero_divisor | compensated result
//  apb      | psel, penable, pwrite, paddr, pwdata, prdata  | calibration registers
//
// One request at a time runs through a sequencer around a bit-serial multiplier
// (one bit of its second operand per cycle, up to the top set bit of that operand)
// and a 64-bit serial divider. Pressure takes ten multiplies and the divide.
// Reset clears calibration and fine temperature. A finished result waits in the
// output register while the next request is already accepted.
`default_nettype none
`include "thp_sensor_compensation_core_macros.svh"
module thp_sensor_compensation_core import thp_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	// request channel
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [1:0]     action,
	input  wire logic [7:0]     byte_msb,
	input  wire logic [7:0]     byte_lsb,
	input  wire logic [7:0]     byte_xlsb,
	// result channel
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [1:0]          reading_kind,
	output logic signed [32:0]  reading_value,
	output logic                zero_divisor,
	// configuration port
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [AW-1:0]  paddr,
	input  wire logic [31:0]    pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	st_t           state_q, state_d;
	logic [1:0]    kind_q, kind_d;
	logic [19:0]   raw_q, raw_d;
	logic [31:0]   ft_q, ft_d;
	logic [31:0]   cal_q [NUM_CAL];
	logic [63:0]   ra_q, ra_d, rb_q, rb_d, rc_q, rc_d, rd_q, rd_d;
	logic [32:0]   val_q, val_d;
	logic          zero_q, zero_d;
	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [32:0]   out_val_q;
	logic          out_zero_q;
	logic          out_load;

	logic          mul_start, mul_busy;
	logic [63:0]   mul_a, mul_b, prod;
	logic          div_start, div_busy;
	logic [63:0]   quo;
	logic          busy;

	// Calibration fields.
	logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic [7:0]  h1, h3, h6;
	logic [11:0] h4, h5;

	assign t1 = cal_q[CAL_T1_T2][15:0];
	assign t2 = cal_q[CAL_T1_T2][31:16];
	assign t3 = cal_q[CAL_T3_P1][15:0];
	assign p1 = cal_q[CAL_T3_P1][31:16];
	assign p2 = cal_q[CAL_P2_P3][15:0];
	assign p3 = cal_q[CAL_P2_P3][31:16];
	assign p4 = cal_q[CAL_P4_P5][15:0];
	assign p5 = cal_q[CAL_P4_P5][31:16];
	assign p6 = cal_q[CAL_P6_P7][15:0];
	assign p7 = cal_q[CAL_P6_P7][31:16];
	assign p8 = cal_q[CAL_P8_P9][15:0];
	assign p9 = cal_q[CAL_P8_P9][31:16];
	assign h1 = cal_q[CAL_H1_H2_H3][7:0];
	assign h2 = cal_q[CAL_H1_H2_H3][23:8];
	assign h3 = cal_q[CAL_H1_H2_H3][31:24];
	assign h4 = cal_q[CAL_H4_H5_H6][11:0];
	assign h5 = cal_q[CAL_H4_H5_H6][23:12];
	assign h6 = cal_q[CAL_H4_H5_H6][31:24];

	// Serial arithmetic units.
	thp_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a_in    (mul_a),
		.b_in    (mul_b),
		.busy    (mul_busy),
		.product (prod)
	);

	thp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (ra_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign busy = mul_busy | div_busy;

	// Write calibration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CAL; i++) begin
				cal_q[i] <= '0;
			end
		end else if (psel && penable && pwrite) begin
			cal_q[paddr[AW-1:2]] <= pwdata;
		end
	end

	assign prdata = cal_q[paddr[AW-1:2]];
	assign pready = 1'b1;

	// Sequencer state and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= '0;
			ft_q    <= '0;
			zero_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			ft_q    <= ft_d;
			zero_q  <= zero_d;
		end
	end

	always_ff @(posedge clk) begin
		raw_q <= raw_d;
		ra_q  <= ra_d;
		rb_q  <= rb_d;
		rc_q  <= rc_d;
		rd_q  <= rd_d;
		val_q <= val_d;
	end

	// Step through the formula of the current request.
	always_comb begin
		logic [31:0] raw32, hraw, tmp32, y32;
		logic [63:0] tmp64;

		state_d   = state_q;
		kind_d    = kind_q;
		raw_d     = raw_q;
		ft_d      = ft_q;
		ra_d      = ra_q;
		rb_d      = rb_q;
		rc_d      = rc_q;
		rd_d      = rd_q;
		val_d     = val_q;
		zero_d    = zero_q;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		in_ready  = (state_q == ST_IDLE);
		raw32     = {12'd0, raw_q};
		hraw      = {16'd0, raw_q[19:4]};
		tmp32     = '0;
		y32       = '0;
		tmp64     = '0;

		if (!busy) begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_d  = action;
						raw_d   = {byte_msb, byte_lsb, byte_xlsb[7:4]};
						state_d = ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					zero_d = 1'b0;
					case (kind_q)
						KIND_TEMP:  state_d = ST_T0;
						KIND_PRESS: state_d = ST_P0;
						KIND_HUM:   state_d = ST_H0;
						default: begin
							val_d   = '0;
							state_d = ST_OUT;
						end
					endcase
				end
				// temperature
				ST_T0: begin
					mul_a     = {32'd0, (raw32 >> 3) - {15'd0, t1, 1'b0}};
					mul_b     = {32'd0, sx16_32(t2)};
					mul_start = 1'b1;
					state_d   = ST_T1;
				end
				ST_T1: begin
					ra_d      = {32'd0, asr32(prod[31:0], 11)};
					tmp32     = (raw32 >> 4) - {16'd0, t1};
					mul_a     = {32'd0, tmp32};
					mul_b     = {32'd0, tmp32};
					mul_start = 1'b1;
					state_d   = ST_T2;
				end
				ST_T2: begin
					mul_a     = {32'd0, asr32(prod[31:0], 12)};
					mul_b     = {32'd0, sx16_32(t3)};
					mul_start = 1'b1;
					state_d   = ST_T3;
				end
				ST_T3: begin
					ft_d    = ra_q[31:0] + asr32(prod[31:0], 14);
					state_d = ST_T4;
				end
				ST_T4: begin
					tmp32   = asr32({ft_q[29:0], 2'b00} + ft_q + T_ROUND, 8);
					val_d   = {tmp32[31], tmp32};
					state_d = ST_OUT;
				end
				// pressure
				ST_P0: begin
					ra_d    = sx32_64(ft_q) - P_TEMP_OFS;
					state_d = ST_P1;
				end
				ST_P1: begin
					mul_a     = ra_q;
					mul_b     = ra_q;
					mul_start = 1'b1;
					state_d   = ST_P2;
				end
				ST_P2: begin
					rb_d      = prod;
					mul_a     = prod;
					mul_b     = sx16_64(p6);
					mul_start = 1'b1;
					state_d   = ST_P3;
				end
				ST_P3: begin
					rc_d      = prod;
					mul_a     = ra_q;
					mul_b     = sx16_64(p5);
					mul_start = 1'b1;
					state_d   = ST_P4;
				end
				ST_P4: begin
					rc_d      = rc_q + (prod << 17);
					mul_a     = rb_q;
					mul_b     = sx16_64(p3);
					mul_start = 1'b1;
					state_d   = ST_P5;
				end
				ST_P5: begin
					rc_d      = rc_q + (sx16_64(p4) << 35);
					rd_d      = asr64(prod, 8);
					mul_a     = ra_q;
					mul_b     = sx16_64(p2);
					mul_start = 1'b1;
					state_d   = ST_P6;
				end
				ST_P6: begin
					rd_d    = rd_q + (prod << 12);
					state_d = ST_P7;
				end
				ST_P7: begin
					mul_a     = rd_q + (64'd1 << 47);
					mul_b     = {48'd0, p1};
					mul_start = 1'b1;
					state_d   = ST_P8;
				end
				ST_P8: begin
					tmp64 = asr64(prod, 33);
					ra_d  = tmp64;
					// drop to zero on an empty divisor
					if (tmp64 == '0) begin
						val_d   = '0;
						zero_d  = 1'b1;
						state_d = ST_OUT;
					end else begin
						state_d = ST_P9;
					end
				end
				ST_P9: begin
					rb_d    = P_RAW_BASE - {44'd0, raw_q};
					state_d = ST_P10;
				end
				ST_P10: begin
					mul_a     = (rb_q << 31) - rc_q;
					mul_b     = P_SCALE;
					mul_start = 1'b1;
					state_d   = ST_P11;
				end
				ST_P11: begin
					div_start = 1'b1;
					state_d   = ST_P12;
				end
				ST_P12: begin
					rb_d      = quo;
					rd_d      = asr64(quo, 13);
					mul_a     = sx16_64(p9);
					mul_b     = asr64(quo, 13);
					mul_start = 1'b1;
					state_d   = ST_P13;
				end
				ST_P13: begin
					mul_a     = prod;
					mul_b     = rd_q;
					mul_start = 1'b1;
					state_d   = ST_P14;
				end
				ST_P14: begin
					rd_d      = asr64(prod, 25);
					mul_a     = rb_q;
					mul_b     = sx16_64(p8);
					mul_start = 1'b1;
					state_d   = ST_P15;
				end
				ST_P15: begin
					rc_d    = asr64(prod, 19);
					rd_d    = rb_q + rd_q;
					state_d = ST_P16;
				end
				ST_P16: begin
					rd_d    = rd_q + rc_q;
					state_d = ST_P17;
				end
				ST_P17: begin
					tmp64   = asr64(rd_q, 8) + (sx16_64(p7) << 4);
					val_d   = {1'b0, tmp64[31:0]};
					state_d = ST_OUT;
				end
				// humidity
				ST_H0: begin
					ra_d    = {32'd0, ft_q - H_TEMP_OFS};
					state_d = ST_H1;
				end
				ST_H1: begin
					mul_a     = {32'd0, sx12_32(h5)};
					mul_b     = {32'd0, ra_q[31:0]};
					mul_start = 1'b1;
					state_d   = ST_H2;
				end
				ST_H2: begin
					rb_d    = {32'd0, (hraw << 14) - (sx12_32(h4) << 20) - prod[31:0]};
					state_d = ST_H3;
				end
				ST_H3: begin
					rb_d      = {32'd0, asr32(rb_q[31:0] + H_ROUND_A, 15)};
					mul_a     = {32'd0, ra_q[31:0]};
					mul_b     = {32'd0, sx8_32(h6)};
					mul_start = 1'b1;
					state_d   = ST_H4;
				end
				ST_H4: begin
					rc_d      = {32'd0, asr32(prod[31:0], 10)};
					mul_a     = {32'd0, ra_q[31:0]};
					mul_b     = {56'd0, h3};
					mul_start = 1'b1;
					state_d   = ST_H5;
				end
				ST_H5: begin
					y32       = asr32(prod[31:0], 11) + H_ADD_Y;
					mul_a     = rc_q;
					mul_b     = {32'd0, y32};
					mul_start = 1'b1;
					state_d   = ST_H6;
				end
				ST_H6: begin
					tmp32     = asr32(prod[31:0], 10) + H_ADD_B;
					mul_a     = {32'd0, tmp32};
					mul_b     = {32'd0, sx16_32(h2)};
					mul_start = 1'b1;
					state_d   = ST_H7;
				end
				ST_H7: begin
					tmp32     = asr32(prod[31:0] + H_ROUND_C, 14);
					mul_a     = rb_q;
					mul_b     = {32'd0, tmp32};
					mul_start = 1'b1;
					state_d   = ST_H8;
				end
				ST_H8: begin
					ra_d      = {32'd0, prod[31:0]};
					tmp32     = asr32(prod[31:0], 15);
					mul_a     = {32'd0, tmp32};
					mul_b     = {32'd0, tmp32};
					mul_start = 1'b1;
					state_d   = ST_H9;
				end
				ST_H9: begin
					mul_a     = {32'd0, asr32(prod[31:0], 7)};
					mul_b     = {56'd0, h1};
					mul_start = 1'b1;
					state_d   = ST_H10;
				end
				ST_H10: begin
					ra_d    = {32'd0, ra_q[31:0] - asr32(prod[31:0], 4)};
					state_d = ST_H11;
				end
				ST_H11: begin
					// clamp to the valid humidity range
					if (ra_q[31]) begin
						tmp32 = '0;
					end else if (ra_q[31:0] > H_LIMIT) begin
						tmp32 = H_LIMIT;
					end else begin
						tmp32 = ra_q[31:0];
					end
					val_d   = {13'd0, tmp32[31:12]};
					state_d = ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= kind_q;
			out_val_q  <= val_q;
			out_zero_q <= zero_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign reading_kind  = out_kind_q;
	assign reading_value = $signed(out_val_q);
	assign zero_divisor  = out_zero_q;

	`THP_ASSERT_NEVER(a_units_exclusive, mul_busy && div_busy, "multiplier and divider both busy")
	`THP_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "second request taken while busy")
	`THP_ASSERT_NEXT(a_ft_update, !(state_q == ST_T3 && !busy), $stable(ft_q), "fine temperature changed outside temperature step")
	`THP_ASSERT_IMP(a_zero_kind, out_valid && zero_divisor, reading_kind == KIND_PRESS, "zero divisor flag on non-pressure result")

endmodule
`default_nettype wire
